// ===== hdl/rfht_pkg.sv =====
// shared types and constants for the rise/fall health tracker
package rfht_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // transition codes
  localparam logic [1:0] TR_NONE = 2'd0;
  localparam logic [1:0] TR_UP   = 2'd1;
  localparam logic [1:0] TR_DOWN = 2'd2;

  // widest index the item can carry
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned IDX_RANGE = 16;

  localparam logic [7:0] CNT_MAX = 8'hff;

  typedef struct packed {
    logic [3:0]  server_index;
    logic        connect_ok;
    logic [15:0] elapsed_seconds;
  } in_item_t;

  typedef struct packed {
    logic [3:0] result_server;
    logic       server_down;
    logic [7:0] server_weight;
    logic       fail_mark;
    logic [1:0] transition;
  } out_item_t;

  // one health record in the table
  typedef struct packed {
    logic [7:0] success_count;
    logic [7:0] failure_count;
    logic       down_flag;
    logic [7:0] weight;
    logic       fail_flag;
  } rec_t;

  // live configuration values
  typedef struct packed {
    logic [7:0]  rise_threshold;
    logic [7:0]  fall_threshold;
    logic [15:0] timeout_seconds;
  } cfg_t;

  // saturating increment of an 8-bit counter
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 8'd1;
  endfunction

endpackage

// ===== hdl/rise_fall_health_tracker.sv =====
// Per-server rise/fall health tracker. Each item is one finished probe; a probe is a success
// when connect_ok is set and elapsed_seconds is below timeout_seconds, otherwise a failure.
// Every item gives exactly one result item carrying the server's down flag, weight, fail mark
// and transition after the probe. Records live in a one-read, one-write memory with a
// registered read: an item is read when accepted, then updated and written back once the
// output takes its result; a write to the same entry is forwarded into the read, so one
// item is taken every cycle unless the output stalls. Results pass the update stage and
// the output register. With no clearing pass, the table reads as all servers up with
// weight 0 after reset. Servers at or above SERVERS change nothing and get zeroed status.
module rise_fall_health_tracker #(
  parameter int unsigned SERVERS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rfht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfht_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rfht_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rfht_pkg::out_item_t               out_item
);

  // only the first sixteen entries are reachable by the index field
  localparam int unsigned DEPTH = (SERVERS < rfht_pkg::IDX_RANGE) ? SERVERS
                                                                  : rfht_pkg::IDX_RANGE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rfht_pkg::cfg_t      cfg;
  rfht_pkg::rec_t      rd_rec;
  rfht_pkg::rec_t      rec_next;
  rfht_pkg::out_item_t result;

  logic                in_accept;
  logic                in_range_a;
  logic [AW-1:0]       rd_addr;
  logic                upd_valid;
  logic                upd_go;
  logic                upd_in_range;
  rfht_pkg::in_item_t  upd_item;
  logic [AW-1:0]       upd_addr;

  rfht_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // read stage
  assign in_range_a = ({{(32 - rfht_pkg::IDX_W){1'b0}}, in_item.server_index} < SERVERS);
  assign rd_addr    = in_range_a ? AW'(in_item.server_index) : '0;
  assign upd_go     = upd_valid && (!out_valid || !out_stall);
  assign in_stall   = upd_valid && !upd_go;
  assign in_accept  = in_valid && !in_stall;

  rfht_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_rec),
    .wr_en   (upd_go && upd_in_range),
    .wr_addr (upd_addr),
    .wr_data (rec_next)
  );

  // update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else if (in_accept) begin
      upd_valid <= 1'b1;
    end else if (upd_go) begin
      upd_valid <= 1'b0;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      upd_item     <= in_item;
      upd_in_range <= in_range_a;
      upd_addr     <= rd_addr;
    end
  end

  rfht_update u_update (
    .rec      (rd_rec),
    .item     (upd_item),
    .in_range (upd_in_range),
    .cfg      (cfg),
    .rec_next (rec_next),
    .result   (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_item <= result;
    end
  end

  // a server that came up is never reported down or fail-marked
  a_up_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.transition == rfht_pkg::TR_UP)
      |-> !out_item.server_down && !out_item.fail_mark)
    else $error("up transition with down flag or fail mark");

  // a server that went down has weight zero and both flags set
  a_down_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.transition == rfht_pkg::TR_DOWN)
      |-> out_item.server_down && out_item.fail_mark && (out_item.server_weight == 8'd0))
    else $error("down transition with inconsistent record");

  // an item finishing its update is registered as a result on the next edge
  a_upd_to_out: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> out_valid && (out_item == $past(result)))
    else $error("updated item not moved to output");

  // the update stage holds its item while the output is blocked
  a_upd_hold: assert property (@(posedge clk) disable iff (rst)
    upd_valid && out_valid && out_stall |=> upd_valid && $stable(upd_item))
    else $error("update stage lost item under stall");

endmodule

// ===== hdl/rfht_cfg_regs.sv =====
// configuration registers: thresholds and timeout
module rfht_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rfht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfht_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rfht_pkg::cfg_t                    cfg
);

  // register write, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_threshold  <= 8'd2;
      cfg.fall_threshold  <= 8'd3;
      cfg.timeout_seconds <= 16'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        rfht_pkg::REG_RISE:    cfg.rise_threshold  <= cfg_data[7:0];
        rfht_pkg::REG_FALL:    cfg.fall_threshold  <= cfg_data[7:0];
        rfht_pkg::REG_TIMEOUT: cfg.timeout_seconds <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rfht_table.sv =====
// health record memory with valid bits and write-to-read forwarding
module rfht_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output rfht_pkg::rec_t    rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  rfht_pkg::rec_t    wr_data
);

  rfht_pkg::rec_t   mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // registered read; a write to the same entry this cycle wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// ===== hdl/rfht_update.sv =====
// record update: classify the probe and apply rise/fall rules
module rfht_update (
  input  rfht_pkg::rec_t      rec,
  input  rfht_pkg::in_item_t  item,
  input  logic                in_range,
  input  rfht_pkg::cfg_t      cfg,
  output rfht_pkg::rec_t      rec_next,
  output rfht_pkg::out_item_t result
);

  logic       success;
  logic [7:0] succ_inc;
  logic [7:0] fail_inc;
  logic [1:0] trans;

  assign success  = item.connect_ok && (item.elapsed_seconds < cfg.timeout_seconds);
  assign succ_inc = rfht_pkg::sat_inc(rec.success_count);
  assign fail_inc = rfht_pkg::sat_inc(rec.failure_count);

  // next record and transition
  always_comb begin
    rec_next = rec;
    trans    = rfht_pkg::TR_NONE;
    if (success) begin
      rec_next.success_count = succ_inc;
      if (rec.down_flag && (succ_inc >= cfg.rise_threshold)) begin
        rec_next.weight        = rfht_pkg::sat_inc(rec.weight);
        rec_next.down_flag     = 1'b0;
        rec_next.fail_flag     = 1'b0;
        rec_next.success_count = '0;
        rec_next.failure_count = '0;
        trans                  = rfht_pkg::TR_UP;
      end
    end else begin
      rec_next.failure_count = fail_inc;
      if (!rec.down_flag && (fail_inc >= cfg.fall_threshold)) begin
        rec_next.weight        = '0;
        rec_next.down_flag     = 1'b1;
        rec_next.fail_flag     = 1'b1;
        rec_next.success_count = '0;
        rec_next.failure_count = '0;
        trans                  = rfht_pkg::TR_DOWN;
      end
    end
  end

  // result item, all zero but for the server index for a server outside the table
  always_comb begin
    result.result_server = item.server_index;
    if (in_range) begin
      result.server_down   = rec_next.down_flag;
      result.server_weight = rec_next.weight;
      result.fail_mark     = rec_next.fail_flag;
      result.transition    = trans;
    end else begin
      result.server_down   = 1'b0;
      result.server_weight = '0;
      result.fail_mark     = 1'b0;
      result.transition    = rfht_pkg::TR_NONE;
    end
  end

endmodule
